// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
// all of them clock on the rising edge and are disabled while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen at an edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/ipga_pkg.sv =====
package ipga_pkg;

  localparam int DIM_W   = 11;
  localparam int CH_W    = 5;
  localparam int PS_W    = 7;
  localparam int PCNT_W  = 20;
  localparam int OADDR_W = 24;
  localparam int TOTAL_W = 21;
  localparam int HW_W    = 22;
  localparam int AREA_W  = 14;
  localparam int PDIM_W  = 19;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes on the config port
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] REG_PATCH_SIDE    = 3'd3;
  localparam logic [2:0] REG_SOURCE_CL     = 3'd4;
  localparam logic [2:0] REG_DEST_CL       = 3'd5;

  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd224;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd224;
  localparam logic [CH_W-1:0]  RST_CHANNEL_COUNT = 5'd3;
  localparam logic [PS_W-1:0]  RST_PATCH_SIDE    = 7'd16;
  localparam logic             RST_SOURCE_CL     = 1'b1;
  localparam logic             RST_DEST_CL       = 1'b1;

  typedef struct packed {
    logic signed [7:0] pixel_value;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0]    pixel_out;
    logic [OADDR_W-1:0]   source_addr;
    logic [OADDR_W-1:0]   dest_addr;
    logic [PCNT_W-1:0]    patch_number;
    logic [TOTAL_W-1:0]   patch_total;
    logic                 last_element;
    logic                 valid_res;
  } out_word_t;

  // saturated registers and derived sizes
  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [CH_W-1:0]    c;
    logic [PS_W-1:0]    p;
    logic               src_cl;
    logic               dst_cl;
    logic [DIM_W-1:0]   nph_m1;
    logic [DIM_W-1:0]   npw_m1;
    logic [PS_W-1:0]    p_m1;
    logic [CH_W-1:0]    c_m1;
    logic [TOTAL_W-1:0] total;
    logic [HW_W-1:0]    hw;
    logic [AREA_W-1:0]  area;
    logic [PDIM_W-1:0]  pdim;
    logic               ok;
  } cfg_view_t;

  typedef struct packed {
    logic busy;
    logic clear;
  } cfg_ctl_t;

  // classified element between front and back
  typedef struct packed {
    logic signed [7:0]   pixel;
    logic [DIM_W-1:0]    pr;
    logic [DIM_W-1:0]    pc;
    logic [PS_W-1:0]     rp;
    logic [PS_W-1:0]     cp;
    logic [CH_W-1:0]     ch;
    logic [PCNT_W-1:0]   pcnt;
    logic                last;
    logic                ok;
  } queue_word_t;

endpackage

// ===== rtl/ipga_fifo.sv =====
`include "assert_macros.svh"

module ipga_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_fifo_overflow, clk, rst_n, wr_en && full, "write into full queue")
  `ASSERT_NEVER(a_fifo_underflow, clk, rst_n, rd_en && empty, "read from empty queue")

endmodule

// ===== rtl/ipga_cfg.sv =====
module ipga_cfg #(
  parameter int MAX_IMAGE_SIDE = 1024,
  parameter int MAX_CHANNELS   = 16,
  parameter int MAX_PATCH_SIDE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipga_pkg::ADDR_W-1:0] paddr,
  input  logic [ipga_pkg::DATA_W-1:0] pwdata,
  output logic [ipga_pkg::DATA_W-1:0] prdata,
  output ipga_pkg::cfg_view_t         view,
  output ipga_pkg::cfg_ctl_t          ctl
);

  import ipga_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_RDY  = 5'b10000
  } der_state_t;

  localparam logic [3:0] STEP_LAST = 4'(DIM_W - 1);

  logic [DIM_W-1:0] height_r;
  logic [DIM_W-1:0] width_r;
  logic [CH_W-1:0]  chans_r;
  logic [PS_W-1:0]  side_r;
  logic             src_cl_r;
  logic             dst_cl_r;
  der_state_t       state_r;
  logic [3:0]       step_r;

  logic [2:0]       idx;
  logic             wr_hit;

  logic [DIM_W-1:0] h_sat;
  logic [DIM_W-1:0] w_sat;
  logic [CH_W-1:0]  c_sat;
  logic [PS_W-1:0]  p_sat;

  // restoring dividers for rows and columns of patches
  logic [PS_W-1:0]  rem_h_r;
  logic [PS_W-1:0]  rem_w_r;
  logic [DIM_W-1:0] quo_h_r;
  logic [DIM_W-1:0] quo_w_r;
  logic [PS_W:0]    rsh_h;
  logic [PS_W:0]    rsh_w;
  logic             ge_h;
  logic             ge_w;
  logic [PS_W-1:0]  rem_h_nxt;
  logic [PS_W-1:0]  rem_w_nxt;

  logic [DIM_W-1:0] nph_c;
  logic [DIM_W-1:0] npw_c;
  logic [HW_W-1:0]  total_full;

  logic [DIM_W-1:0]   nph_m1_r;
  logic [DIM_W-1:0]   npw_m1_r;
  logic [TOTAL_W-1:0] total_r;
  logic [HW_W-1:0]    hw_r;
  logic [AREA_W-1:0]  area_r;
  logic [PDIM_W-1:0]  pdim_r;
  logic               ok_r;

  assign idx    = paddr[4:2];
  assign wr_hit = psel && penable && pwrite && (idx <= REG_DEST_CL);

  assign h_sat = (height_r > MAX_IMAGE_SIDE) ? DIM_W'(MAX_IMAGE_SIDE) : height_r;
  assign w_sat = (width_r > MAX_IMAGE_SIDE) ? DIM_W'(MAX_IMAGE_SIDE) : width_r;
  assign c_sat = (chans_r > MAX_CHANNELS) ? CH_W'(MAX_CHANNELS) : chans_r;
  assign p_sat = (side_r > MAX_PATCH_SIDE) ? PS_W'(MAX_PATCH_SIDE) : side_r;

  assign rsh_h     = {rem_h_r, quo_h_r[DIM_W-1]};
  assign rsh_w     = {rem_w_r, quo_w_r[DIM_W-1]};
  assign ge_h      = (rsh_h >= {1'b0, p_sat});
  assign ge_w      = (rsh_w >= {1'b0, p_sat});
  assign rem_h_nxt = ge_h ? PS_W'(rsh_h - {1'b0, p_sat}) : rsh_h[PS_W-1:0];
  assign rem_w_nxt = ge_w ? PS_W'(rsh_w - {1'b0, p_sat}) : rsh_w[PS_W-1:0];

  assign nph_c      = (p_sat == '0) ? '0 : quo_h_r;
  assign npw_c      = (p_sat == '0) ? '0 : quo_w_r;
  assign total_full = nph_c * npw_c;

  always_comb begin
    case (idx)
      REG_IMAGE_HEIGHT:  prdata = DATA_W'(height_r);
      REG_IMAGE_WIDTH:   prdata = DATA_W'(width_r);
      REG_CHANNEL_COUNT: prdata = DATA_W'(chans_r);
      REG_PATCH_SIDE:    prdata = DATA_W'(side_r);
      REG_SOURCE_CL:     prdata = DATA_W'(src_cl_r);
      REG_DEST_CL:       prdata = DATA_W'(dst_cl_r);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= RST_IMAGE_HEIGHT;
      width_r  <= RST_IMAGE_WIDTH;
      chans_r  <= RST_CHANNEL_COUNT;
      side_r   <= RST_PATCH_SIDE;
      src_cl_r <= RST_SOURCE_CL;
      dst_cl_r <= RST_DEST_CL;
      state_r  <= ST_LOAD;
      step_r   <= '0;
    end else if (wr_hit) begin
      case (idx)
        REG_IMAGE_HEIGHT:  height_r <= pwdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:   width_r  <= pwdata[DIM_W-1:0];
        REG_CHANNEL_COUNT: chans_r  <= pwdata[CH_W-1:0];
        REG_PATCH_SIDE:    side_r   <= pwdata[PS_W-1:0];
        REG_SOURCE_CL:     src_cl_r <= pwdata[0];
        REG_DEST_CL:       dst_cl_r <= pwdata[0];
        default: begin
        end
      endcase
      state_r <= ST_LOAD;
    end else begin
      case (state_r)
        ST_LOAD: begin
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: state_r <= ST_MUL2;
        ST_MUL2: state_r <= ST_RDY;
        ST_RDY:  state_r <= ST_RDY;
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        rem_h_r <= '0;
        rem_w_r <= '0;
        quo_h_r <= h_sat;
        quo_w_r <= w_sat;
      end
      ST_DIV: begin
        rem_h_r <= rem_h_nxt;
        rem_w_r <= rem_w_nxt;
        quo_h_r <= {quo_h_r[DIM_W-2:0], ge_h};
        quo_w_r <= {quo_w_r[DIM_W-2:0], ge_w};
      end
      ST_MUL1: begin
        nph_m1_r <= nph_c - 1'b1;
        npw_m1_r <= npw_c - 1'b1;
        total_r  <= total_full[TOTAL_W-1:0];
        hw_r     <= h_sat * w_sat;
        area_r   <= p_sat * p_sat;
        ok_r     <= (c_sat != '0) && (nph_c != '0) && (npw_c != '0);
      end
      ST_MUL2: begin
        pdim_r <= area_r * c_sat;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    view.w      = w_sat;
    view.c      = c_sat;
    view.p      = p_sat;
    view.src_cl = src_cl_r;
    view.dst_cl = dst_cl_r;
    view.nph_m1 = nph_m1_r;
    view.npw_m1 = npw_m1_r;
    view.p_m1   = p_sat - 1'b1;
    view.c_m1   = c_sat - 1'b1;
    view.total  = total_r;
    view.hw     = hw_r;
    view.area   = area_r;
    view.pdim   = pdim_r;
    view.ok     = ok_r;
  end

  assign ctl.busy  = (state_r != ST_RDY);
  assign ctl.clear = wr_hit;

endmodule

// ===== rtl/ipga_front.sv =====
module ipga_front #(
  parameter int MAX_IMAGE_SIDE = 1024,
  parameter int MAX_CHANNELS   = 16,
  parameter int MAX_PATCH_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  ipga_pkg::in_word_t    in_word,
  input  logic                  clear,
  input  ipga_pkg::cfg_view_t   view,
  output ipga_pkg::queue_word_t q_word
);

  import ipga_pkg::*;

  localparam int PR_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;
  localparam int PI_W = (MAX_PATCH_SIDE > 1) ? $clog2(MAX_PATCH_SIDE) : 1;
  localparam int CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [PR_W-1:0]   pr_r, pc_r, pr_e, pc_e, pr_nxt, pc_nxt;
  logic [PI_W-1:0]   rp_r, cp_r, rp_e, cp_e, rp_nxt, cp_nxt;
  logic [CI_W-1:0]   ch_r, ch_e, ch_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_e, pcnt_nxt;
  logic              ch_wrap, cp_wrap, rp_wrap, pc_wrap, pr_wrap;

  // restart drops the sweep back to its first element before this word
  assign pr_e   = in_word.restart ? '0 : pr_r;
  assign pc_e   = in_word.restart ? '0 : pc_r;
  assign rp_e   = in_word.restart ? '0 : rp_r;
  assign cp_e   = in_word.restart ? '0 : cp_r;
  assign ch_e   = in_word.restart ? '0 : ch_r;
  assign pcnt_e = in_word.restart ? '0 : pcnt_r;

  assign ch_wrap = (CH_W'(ch_e) == view.c_m1);
  assign cp_wrap = ch_wrap && (PS_W'(cp_e) == view.p_m1);
  assign rp_wrap = cp_wrap && (PS_W'(rp_e) == view.p_m1);
  assign pc_wrap = rp_wrap && (DIM_W'(pc_e) == view.npw_m1);
  assign pr_wrap = pc_wrap && (DIM_W'(pr_e) == view.nph_m1);

  always_comb begin
    ch_nxt   = ch_wrap ? '0 : ch_e + 1'b1;
    cp_nxt   = cp_e;
    rp_nxt   = rp_e;
    pc_nxt   = pc_e;
    pr_nxt   = pr_e;
    pcnt_nxt = pcnt_e;
    if (ch_wrap) begin
      cp_nxt = cp_wrap ? '0 : cp_e + 1'b1;
    end
    if (cp_wrap) begin
      rp_nxt = rp_wrap ? '0 : rp_e + 1'b1;
    end
    if (rp_wrap) begin
      pc_nxt   = pc_wrap ? '0 : pc_e + 1'b1;
      pcnt_nxt = pr_wrap ? '0 : pcnt_e + 1'b1;
    end
    if (pc_wrap) begin
      pr_nxt = pr_wrap ? '0 : pr_e + 1'b1;
    end
    if (!view.ok) begin
      ch_nxt   = '0;
      cp_nxt   = '0;
      rp_nxt   = '0;
      pc_nxt   = '0;
      pr_nxt   = '0;
      pcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pr_r   <= '0;
      pc_r   <= '0;
      rp_r   <= '0;
      cp_r   <= '0;
      ch_r   <= '0;
      pcnt_r <= '0;
    end else if (accept) begin
      pr_r   <= pr_nxt;
      pc_r   <= pc_nxt;
      rp_r   <= rp_nxt;
      cp_r   <= cp_nxt;
      ch_r   <= ch_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  always_comb begin
    q_word.pixel = in_word.pixel_value;
    q_word.ok    = view.ok;
    if (view.ok) begin
      q_word.pr   = DIM_W'(pr_e);
      q_word.pc   = DIM_W'(pc_e);
      q_word.rp   = PS_W'(rp_e);
      q_word.cp   = PS_W'(cp_e);
      q_word.ch   = CH_W'(ch_e);
      q_word.pcnt = pcnt_e;
      q_word.last = pr_wrap;
    end else begin
      q_word.pr   = '0;
      q_word.pc   = '0;
      q_word.rp   = '0;
      q_word.cp   = '0;
      q_word.ch   = '0;
      q_word.pcnt = '0;
      q_word.last = 1'b0;
    end
  end

endmodule

// ===== rtl/ipga_back.sv =====
`include "assert_macros.svh"

module ipga_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipga_pkg::queue_word_t head,
  input  logic                  head_valid,
  output logic                  head_take,
  input  ipga_pkg::cfg_view_t   view,
  input  logic                  pop,
  output logic                  empty,
  output ipga_pkg::out_word_t   out_word
);

  import ipga_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r;

  // stage 1: pixel coordinates, in-patch offset, channel planes, patch base
  logic [17:0]        y_full, x_full;
  logic [AREA_W-1:0]  rq_c;
  logic [PDIM_W-1:0]  charea_c;
  logic [26:0]        chhw_c;
  logic [OADDR_W-1:0] pbase_c;

  logic signed [7:0]  s1_pixel;
  logic [DIM_W-1:0]   s1_y, s1_x;
  logic [AREA_W-1:0]  s1_rq;
  logic [CH_W-1:0]    s1_ch;
  logic [PDIM_W-1:0]  s1_charea;
  logic [26:0]        s1_chhw;
  logic [OADDR_W-1:0] s1_pbase;
  logic [PCNT_W-1:0]  s1_pcnt;
  logic               s1_last, s1_ok;

  // stage 2: row-major pixel index and offset inside the patch
  logic [HW_W-1:0]    yw_c;
  logic [PDIM_W-1:0]  doff_c;

  logic signed [7:0]  s2_pixel;
  logic [HW_W-1:0]    s2_yw;
  logic [CH_W-1:0]    s2_ch;
  logic [26:0]        s2_chhw;
  logic [PDIM_W-1:0]  s2_doff;
  logic [OADDR_W-1:0] s2_pbase;
  logic [PCNT_W-1:0]  s2_pcnt;
  logic               s2_last, s2_ok;

  // stage 3: final addresses
  logic [OADDR_W-1:0] src_hwc, src_chw;

  assign en        = !v3_r || pop;
  assign head_take = head_valid && en;
  assign empty     = !v3_r;

  assign y_full   = head.pr * view.p + head.rp;
  assign x_full   = head.pc * view.p + head.cp;
  assign rq_c     = head.rp * view.p + head.cp;
  assign charea_c = head.ch * view.area;
  assign chhw_c   = head.ch * view.hw;
  assign pbase_c  = OADDR_W'(head.pcnt) * OADDR_W'(view.pdim);

  assign yw_c   = s1_y * view.w + s1_x;
  assign doff_c = view.dst_cl ? (s1_rq * view.c + s1_ch) : (s1_charea + s1_rq);

  assign src_hwc = OADDR_W'(s2_yw) * OADDR_W'(view.c) + OADDR_W'(s2_ch);
  assign src_chw = OADDR_W'(s2_chhw) + OADDR_W'(s2_yw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= head_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pixel  <= head.pixel;
      s1_y      <= y_full[DIM_W-1:0];
      s1_x      <= x_full[DIM_W-1:0];
      s1_rq     <= rq_c;
      s1_ch     <= head.ch;
      s1_charea <= charea_c;
      s1_chhw   <= chhw_c;
      s1_pbase  <= pbase_c;
      s1_pcnt   <= head.pcnt;
      s1_last   <= head.last;
      s1_ok     <= head.ok;

      s2_pixel <= s1_pixel;
      s2_yw    <= yw_c;
      s2_ch    <= s1_ch;
      s2_chhw  <= s1_chhw;
      s2_doff  <= doff_c;
      s2_pbase <= s1_pbase;
      s2_pcnt  <= s1_pcnt;
      s2_last  <= s1_last;
      s2_ok    <= s1_ok;

      out_word.pixel_out    <= s2_pixel;
      out_word.source_addr  <= view.src_cl ? src_hwc : src_chw;
      out_word.dest_addr    <= s2_pbase + OADDR_W'(s2_doff);
      out_word.patch_number <= s2_pcnt;
      out_word.patch_total  <= s2_ok ? view.total : '0;
      out_word.last_element <= s2_last;
      out_word.valid_res    <= s2_ok;
    end
  end

  `ASSERT_CLK(a_last_is_valid, clk, rst_n, !empty && out_word.last_element |-> out_word.valid_res, "end of sweep flagged on an invalid word")

endmodule

// ===== rtl/image_patch_gather_addresser.sv =====
// patch gather address sequencer
// input queue side: push a fetched pixel word while full is low; restart in the
// word begins a new sweep with that pixel. result queue side: while empty is
// low the oldest result word (pixel, source and destination element index,
// patch number, patch count, end-of-sweep and valid flags) sits on out_word,
// and pop takes it
// throughput is one word per cycle sustained while the receiver pops and no
// write is in work; each result goes through the three-stage pipeline in the back end
// a four-word queue between the sequencer front and the address back lets
// pushes go on while the receiver stalls; once it fills, full rises
// the config port is apb-style at byte address 4*index, zero wait states
// after reset and after every register write, full stays high while a
// shift-subtract divider works out patches per row and column and the
// patch sizes are multiplied up; a write also returns the sweep to its start
// with no whole patch in the image the pixel still passes, valid_res is low
// and every other field reads zero
`include "assert_macros.svh"

module image_patch_gather_addresser #(
  parameter int MAX_IMAGE_SIDE = 1024,
  parameter int MAX_CHANNELS   = 16,
  parameter int MAX_PATCH_SIDE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input queue
  input  logic                        push,
  output logic                        full,
  input  ipga_pkg::in_word_t          in_word,
  // result queue
  output logic                        empty,
  input  logic                        pop,
  output ipga_pkg::out_word_t         out_word,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipga_pkg::ADDR_W-1:0] paddr,
  input  logic [ipga_pkg::DATA_W-1:0] pwdata,
  output logic [ipga_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  import ipga_pkg::*;

  localparam int QDEPTH = 4;

  cfg_view_t   view;
  cfg_ctl_t    ctl;
  queue_word_t q_in;
  queue_word_t q_head;
  logic        accept;
  logic        q_full;
  logic        q_empty;
  logic        q_take;

  assign pready = 1'b1;

  // hold off pushes while sizes are being derived and on the write edge itself
  assign full   = ctl.busy || ctl.clear || q_full;
  assign accept = push && !full;

  // registers plus derived patch sizes
  ipga_cfg #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_PATCH_SIDE (MAX_PATCH_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .view    (view),
    .ctl     (ctl)
  );

  // sweep counters, tags each pixel with its position
  ipga_front #(
    .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_PATCH_SIDE (MAX_PATCH_SIDE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .clear   (ctl.clear),
    .view    (view),
    .q_word  (q_in)
  );

  // decoupling queue between front and back
  ipga_fifo #(
    .WIDTH ($bits(queue_word_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (q_in),
    .rd_en   (q_take),
    .rd_data (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // address pipeline and result register
  ipga_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_take  (q_take),
    .view       (view),
    .pop        (pop),
    .empty      (empty),
    .out_word   (out_word)
  );

  `ASSERT_CLK(a_wr_blocks_push, clk, rst_n, ctl.clear |=> full, "push open after a write")

endmodule

// ===== tb/tb_image_patch_gather_addresser.sv =====
module tb_image_patch_gather_addresser;
  timeunit 1ns;
  timeprecision 1ps;

  import ipga_pkg::*;

  // saturation limits, matching the block's default parameters
  localparam int unsigned MAX_SIDE  = 1024;
  localparam int unsigned MAX_CHANS = 16;
  localparam int unsigned MAX_PSIDE = 64;
  localparam int          PHASES    = 14;
  localparam int          PHASE_LEN = 100;

  // tracks the sweep position and works out the address word for each pixel
  class patch_addr_tracker;
    bit [DIM_W-1:0] img_h, img_w;
    bit [CH_W-1:0]  chans;
    bit [PS_W-1:0]  side;
    bit             src_cl, dst_cl;
    bit [9:0]       prow, pcol;
    bit [5:0]       rip, cip;
    bit [3:0]       chi;
    bit [19:0]      pcnt;
    out_word_t      expected_words[$];
    int             mismatches;

    function new();
      img_h  = RST_IMAGE_HEIGHT;
      img_w  = RST_IMAGE_WIDTH;
      chans  = RST_CHANNEL_COUNT;
      side   = RST_PATCH_SIDE;
      src_cl = RST_SOURCE_CL;
      dst_cl = RST_DEST_CL;
      mismatches = 0;
      clear_sweep();
    endfunction

    function void clear_sweep();
      prow = '0;
      pcol = '0;
      rip  = '0;
      cip  = '0;
      chi  = '0;
      pcnt = '0;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned val);
      case (idx)
        REG_IMAGE_HEIGHT:  img_h  = val[DIM_W-1:0];
        REG_IMAGE_WIDTH:   img_w  = val[DIM_W-1:0];
        REG_CHANNEL_COUNT: chans  = val[CH_W-1:0];
        REG_PATCH_SIDE:    side   = val[PS_W-1:0];
        REG_SOURCE_CL:     src_cl = val[0];
        REG_DEST_CL:       dst_cl = val[0];
        default: return;
      endcase
      clear_sweep();
    endfunction

    function out_word_t predict(in_word_t w);
      int unsigned     h, wd, c, p, nph, npw;
      longint unsigned y, x, src, dst, area;
      out_word_t       r;
      h  = (img_h > MAX_SIDE) ? MAX_SIDE : 32'(img_h);
      wd = (img_w > MAX_SIDE) ? MAX_SIDE : 32'(img_w);
      c  = (chans > MAX_CHANS) ? MAX_CHANS : 32'(chans);
      p  = (side > MAX_PSIDE) ? MAX_PSIDE : 32'(side);
      if (w.restart) clear_sweep();
      r = '0;
      r.pixel_out = w.pixel_value;
      nph = 0;
      npw = 0;
      if (p != 0) begin
        nph = h / p;
        npw = wd / p;
      end
      // no whole patch: pixel passes, everything else zero
      if (c == 0 || nph == 0 || npw == 0) begin
        clear_sweep();
        return r;
      end
      y = 64'(prow) * p + 64'(rip);
      x = 64'(pcol) * p + 64'(cip);
      if (src_cl) src = (y * wd + x) * c + 64'(chi);
      else src = 64'(chi) * h * wd + y * wd + x;
      area = 64'(p) * p;
      if (dst_cl) dst = (64'(rip) * p + 64'(cip)) * c + 64'(chi);
      else dst = 64'(chi) * area + 64'(rip) * p + 64'(cip);
      dst = dst + 64'(pcnt) * area * c;
      r.source_addr  = src[OADDR_W-1:0];
      r.dest_addr    = dst[OADDR_W-1:0];
      r.patch_number = pcnt;
      r.patch_total  = TOTAL_W'(nph * npw);
      r.last_element = 32'(prow) == nph - 1 && 32'(pcol) == npw - 1 &&
                       32'(rip) == p - 1 && 32'(cip) == p - 1 && 32'(chi) == c - 1;
      r.valid_res    = 1'b1;
      // step on: channel, column in patch, row in patch, patch column, patch row
      if (32'(chi) + 1 < c) chi++;
      else begin
        chi = '0;
        if (32'(cip) + 1 < p) cip++;
        else begin
          cip = '0;
          if (32'(rip) + 1 < p) rip++;
          else begin
            rip = '0;
            pcnt++;
            if (32'(pcol) + 1 < npw) pcol++;
            else begin
              pcol = '0;
              if (32'(prow) + 1 < nph) prow++;
              else begin
                prow = '0;
                pcnt = '0;
              end
            end
          end
        end
      end
      return r;
    endfunction

    function void note_pixel(in_word_t w);
      expected_words.push_back(predict(w));
    endfunction

    function string show(out_word_t o);
      return $sformatf("pix %0d src %0d dst %0d patch %0d total %0d last %0b valid %0b",
                       o.pixel_out, o.source_addr, o.dest_addr, o.patch_number,
                       o.patch_total, o.last_element, o.valid_res);
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(got));
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.pixel_out !== exp_w.pixel_out || got.source_addr !== exp_w.source_addr ||
          got.dest_addr !== exp_w.dest_addr || got.patch_number !== exp_w.patch_number ||
          got.patch_total !== exp_w.patch_total || got.last_element !== exp_w.last_element ||
          got.valid_res !== exp_w.valid_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
                   show(exp_w), show(got));
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                push;
  logic                full;
  in_word_t            in_word;
  logic                empty;
  logic                pop;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  patch_addr_tracker   tracker = new();

  // chance in a hundred that the sender idles / the receiver stalls in a cycle
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  image_patch_gather_addresser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic bit roll(int pct);
    return int'($urandom_range(99)) < pct;
  endfunction

  function automatic in_word_t make_word(int pix, bit rs);
    in_word_t w;
    w.pixel_value = 8'(pix);
    w.restart     = rs;
    return w;
  endfunction

  // receiver: pop decided at the falling edge, result taken at the rising edge
  always @(negedge clk) begin
    pop <= rst_n && !roll(recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) tracker.check_word(out_word);
  end

  // idling profiles: none, sender idle, receiver stalling, both
  task automatic set_mode(int m);
    case (m)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 81;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 81;
      end
      default: begin
        send_idle_pct = 23;
        recv_stall_pct = 23;
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_pixel(in_word_t w);
    if (roll(send_idle_pct)) begin
      push <= 1'b0;
      do @(negedge clk); while (roll(send_idle_pct));
    end
    push    <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    tracker.note_pixel(w);
    @(negedge clk);
  endtask

  // sender holds off until every outstanding result word has come back
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (tracker.expected_words.size() != 0);
  endtask

  // setup then access phase; psel stays high across back-to-back writes
  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, val);
  endtask

  task automatic cfg_idle();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // only touched with the block idle, so no result word is outstanding when a register write lands
  task automatic set_geometry(int unsigned h, int unsigned w, int unsigned c,
                              int unsigned p, bit scl, bit dcl);
    drain();
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_CHANNEL_COUNT, c);
    write_reg(REG_PATCH_SIDE, p);
    write_reg(REG_SOURCE_CL, 32'(scl));
    write_reg(REG_DEST_CL, 32'(dcl));
    cfg_idle();
  endtask

  // random geometry: mostly small images so sweeps wrap, some degenerate or huge
  task automatic random_geometry();
    int unsigned h, w, c, p, pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      p = $urandom_range(1, 4);
      h = $urandom_range(p, 12);
      w = $urandom_range(p, 12);
      c = $urandom_range(1, 3);
    end else if (pick < 72) begin
      p = $urandom_range(1, 2);
      h = $urandom_range(p, 4);
      w = $urandom_range(p, 4);
      c = $urandom_range(1, 2);
    end else if (pick < 85) begin
      // no whole patch: zero side, zero channels, or side beyond one dimension
      h = $urandom_range(1, 20);
      w = $urandom_range(1, 20);
      c = $urandom_range(0, 31);
      p = $urandom_range(0, 127);
      case ($urandom_range(2))
        0: p = 0;
        1: c = 0;
        default: p = (roll(50) ? h : w) + $urandom_range(1, 10);
      endcase
    end else begin
      // whole register range, oversized values included
      h = $urandom_range(0, 2047);
      w = $urandom_range(0, 2047);
      c = $urandom_range(0, 31);
      p = $urandom_range(0, 127);
    end
    set_geometry(h, w, c, p, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    int hold_at;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_word = '0;
    pop     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry, pixel extremes, restart on the fourth pixel of the sweep
    set_mode(0);
    send_pixel(make_word(-128, 1'b0));
    send_pixel(make_word(127, 1'b0));
    send_pixel(make_word(0, 1'b0));
    send_pixel(make_word(-1, 1'b1));

    // one 2x2 patch, two planes, both sides channel-first: full sweep plus wrap
    set_geometry(2, 2, 2, 2, 1'b0, 1'b0);
    repeat (9) send_pixel(make_word($urandom_range(255), 1'b0));

    // oversized registers saturate to the maxima
    set_geometry(2047, 1025, 31, 127, 1'b1, 1'b0);
    send_pixel(make_word(85, 1'b0));
    send_pixel(make_word(-86, 1'b1));

    // no whole patch: no channels, zero side, side taller or wider than the image
    set_geometry(16, 16, 0, 4, 1'b1, 1'b1);
    send_pixel(make_word(1, 1'b0));
    set_geometry(16, 16, 2, 0, 1'b0, 1'b1);
    send_pixel(make_word(-2, 1'b1));
    set_geometry(3, 40, 1, 5, 1'b1, 1'b0);
    send_pixel(make_word(3, 1'b0));
    set_geometry(40, 3, 1, 5, 1'b0, 1'b0);
    send_pixel(make_word(-4, 1'b0));

    // a lone register write mid-sweep sends the sweep back to its start
    set_geometry(4, 4, 1, 2, 1'b1, 1'b1);
    repeat (3) send_pixel(make_word($urandom_range(255), 1'b0));
    drain();
    write_reg(REG_DEST_CL, 0);
    cfg_idle();
    repeat (2) send_pixel(make_word($urandom_range(255), 1'b0));
    // restart in the middle of a sweep
    send_pixel(make_word($urandom_range(255), 1'b1));

    // random phases, cycling through the idling profiles
    for (int ph = 0; ph < PHASES; ph++) begin
      set_mode(ph % 4);
      random_geometry();
      hold_at = $urandom_range(PHASE_LEN - 1);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (i == hold_at) drain();
        send_pixel(make_word($urandom_range(255), roll(2)));
      end
    end

    // let the last words out, then idle so that any stray word would show
    drain();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ipga_pkg.sv
rtl/ipga_fifo.sv
rtl/ipga_cfg.sv
rtl/ipga_front.sv
rtl/ipga_back.sv
rtl/image_patch_gather_addresser.sv
tb/tb_image_patch_gather_addresser.sv
